### design/srpc_pkg.sv
// Shared constants, codes and control types of the raw-to-physical converter.
`default_nettype none
package srpc_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 16;

  localparam int unsigned SAMPLE_W   = 17;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned PHYS_W     = 32;
  localparam int unsigned VALUE_W    = 48;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FRAC_W     = 16;

  localparam int unsigned ACC_W  = 84;
  localparam int unsigned DPHY_W = PHYS_W + 1;
  localparam int unsigned NUM_W  = DPHY_W + SAMPLE_W;
  localparam int unsigned DIV_W  = NUM_W + 1;
  localparam int unsigned REM_W  = RAW_W + 1;
  localparam int unsigned BIT_W  = $clog2(DIV_W);

  localparam logic [MODE_W-1:0] MODE_PASS   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUAD   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CUBIC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TABLE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_D = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SAT         = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_WRITTEN     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_INTERVAL = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_SAT, S_CHK_FIRST, S_CHK_LAST, S_SCAN,
    S_MUL_TBL, S_DIV_PREP, S_DIV, S_INTERP, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL_BIT, OP_ADD_COEF, OP_RES_POLY, OP_RES_RDATA,
    OP_RES_LO, OP_RES_NONE, OP_KEEP_LO, OP_INTERP_SETUP, OP_MUL_TBL,
    OP_DIV_PREP, OP_DIV_STEP, OP_RES_INTERP, OP_FINISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       msb;
    logic [1:0] coef_sel;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              in_kind;
    logic              le_rd;
    logic              ge_rd;
    logic              in_lo;
    logic              zero_width;
    logic              out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/srpc_in_if.sv
// Input channel carrying one sample or one table point per word.
`default_nettype none
interface srpc_in_if import srpc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [SAMPLE_W-1:0] sample;
  logic [INDEX_W-1:0]         point_index;
  logic [RAW_W-1:0]           point_raw;
  logic signed [PHYS_W-1:0]   point_phys;

  modport source (output valid, kind, sample, point_index, point_raw, point_phys,
                  input ready);
  modport sink (input valid, kind, sample, point_index, point_raw, point_phys,
                output ready);
endinterface
`default_nettype wire

### design/srpc_out_if.sv
// Output channel carrying one physical value and its status per word.
`default_nettype none
interface srpc_out_if import srpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface
`default_nettype wire

### design/srpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### design/srpc_ctrl.sv
// Controller state machine sequencing polynomial, table search and division.
`default_nettype none
module srpc_ctrl import srpc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire sts_t                           sts_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] last_idx_i,
  output      cmd_t                           cmd_o,
  output      logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_o
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  state_e         state_q, state_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic [1:0]     step_q, step_d;
  logic [AW-1:0]  idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bit_q   <= '0;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    step_d  = step_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          bit_d  = '0;
          step_d = '0;
          if (sts_i.in_kind) begin
            state_d = S_DONE;
          end else if (sts_i.mode == MODE_LINEAR || sts_i.mode == MODE_QUAD ||
                       sts_i.mode == MODE_CUBIC) begin
            state_d = S_MUL;
          end else if (sts_i.mode == MODE_TABLE) begin
            state_d = S_CHK_FIRST;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL: begin
        bit_d = bit_q + 1'b1;
        if (bit_q == BIT_W'(SAMPLE_W - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        step_d = step_q + 1'b1;
        bit_d  = '0;
        if (step_q + 2'd1 == sts_i.mode[1:0]) begin
          state_d = S_SAT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_SAT: state_d = S_DONE;
      S_CHK_FIRST: begin
        state_d = sts_i.le_rd ? S_DONE : S_CHK_LAST;
      end
      S_CHK_LAST: begin
        if (sts_i.ge_rd) begin
          state_d = S_DONE;
        end else begin
          idx_d   = AW'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.in_lo) begin
          state_d = sts_i.zero_width ? S_DONE : S_MUL_TBL;
        end else if (idx_q == last_idx_i) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_MUL_TBL: state_d = S_DIV_PREP;
      S_DIV_PREP: begin
        bit_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        bit_d = bit_q + 1'b1;
        if (bit_q == BIT_W'(DIV_W - 1)) begin
          state_d = S_INTERP;
        end
      end
      S_INTERP: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.msb      = (bit_q == BIT_W'(SAMPLE_W - 1));
    cmd_o.coef_sel = step_q;
    rd_addr_o      = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
        end
      end
      S_MUL:      cmd_o.op = OP_MUL_BIT;
      S_ADD:      cmd_o.op = OP_ADD_COEF;
      S_SAT:      cmd_o.op = OP_RES_POLY;
      S_CHK_FIRST: begin
        if (sts_i.le_rd) begin
          cmd_o.op = OP_RES_RDATA;
        end else begin
          cmd_o.op  = OP_KEEP_LO;
          rd_addr_o = last_idx_i;
        end
      end
      S_CHK_LAST: begin
        if (sts_i.ge_rd) begin
          cmd_o.op = OP_RES_RDATA;
        end else begin
          rd_addr_o = AW'(1);
        end
      end
      S_SCAN: begin
        if (sts_i.in_lo) begin
          cmd_o.op = sts_i.zero_width ? OP_RES_LO : OP_INTERP_SETUP;
        end else if (idx_q == last_idx_i) begin
          cmd_o.op = OP_RES_NONE;
        end else begin
          cmd_o.op  = OP_KEEP_LO;
          rd_addr_o = idx_q + 1'b1;
        end
      end
      S_MUL_TBL:  cmd_o.op = OP_MUL_TBL;
      S_DIV_PREP: cmd_o.op = OP_DIV_PREP;
      S_DIV:      cmd_o.op = OP_DIV_STEP;
      S_INTERP:   cmd_o.op = OP_RES_INTERP;
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FINISH;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= last_idx_i))
    else $error("table scan went past the last point");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted word did not start work");

endmodule
`default_nettype wire

### design/srpc_dpath.sv
// Datapath: configuration, table memory, serial multiplier, divider and result.
`default_nettype none
module srpc_dpath import srpc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]          cfg_data_i,
  input  wire logic                           in_kind_i,
  input  wire logic signed [SAMPLE_W-1:0]     in_sample_i,
  input  wire logic [INDEX_W-1:0]             in_point_index_i,
  input  wire logic [RAW_W-1:0]               in_point_raw_i,
  input  wire logic signed [PHYS_W-1:0]       in_point_phys_i,
  input  wire cmd_t                           cmd_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_i,
  output      sts_t                           sts_o,
  output      logic [$clog2(TABLE_DEPTH)-1:0] last_idx_o,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic signed [VALUE_W-1:0]      out_value_o,
  output      logic [STATUS_W-1:0]            out_status_o
);
  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned NW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW  = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int unsigned EW  = RAW_W + PHYS_W;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  logic [MODE_W-1:0]        mode_q;
  logic signed [PHYS_W-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic [COUNT_W-1:0]       count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PASS;
      coef_a_q <= '0;
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= '0;
      count_q  <= COUNT_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_COEF_A: coef_a_q <= cfg_data_i;
        CFG_COEF_B: coef_b_q <= cfg_data_i;
        CFG_COEF_C: coef_c_q <= cfg_data_i;
        CFG_COEF_D: coef_d_q <= cfg_data_i;
        CFG_COUNT:  count_q  <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] cnt_ext, n_eff;
  always_comb begin
    cnt_ext = CW'(count_q);
    if (cnt_ext == '0) begin
      n_eff = CW'(1);
    end else if (cnt_ext > CW'(TABLE_DEPTH)) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = cnt_ext;
    end
  end
  assign last_idx_o = AW'(n_eff - 1'b1);

  logic            ram_we;
  logic [EW-1:0]   rd_data;
  logic [RAW_W-1:0] rd_raw;
  logic signed [PHYS_W-1:0] rd_phys;

  assign ram_we = (cmd_i.op == OP_LOAD) && in_kind_i &&
                  (32'(in_point_index_i) < TABLE_DEPTH);

  srpc_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_point_index_i)),
    .wdata_i ({in_point_raw_i, in_point_phys_i}),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );
  assign rd_raw  = rd_data[EW-1:PHYS_W];
  assign rd_phys = rd_data[PHYS_W-1:0];

  logic signed [SAMPLE_W-1:0] samp_q;
  logic [SAMPLE_W-1:0]        xs_q;
  logic signed [ACC_W-1:0]    mcand_q, prod_q;
  logic [RAW_W-1:0]           lo_raw_q, ds_q, dw_q;
  logic signed [PHYS_W-1:0]   lo_phys_q;
  logic signed [DPHY_W-1:0]   dphys_q;
  logic signed [NUM_W-1:0]    num_q;
  logic                       neg_q;
  logic [DIV_W-1:0]           dvd_q;
  logic [REM_W-1:0]           rem_q, dvs_q;
  logic signed [VALUE_W-1:0]  res_value_q;
  logic [STATUS_W-1:0]        res_status_q;

  logic [RAW_W-1:0]        s;
  logic signed [PHYS_W-1:0] coef_next;
  logic signed [ACC_W-1:0] horner_sum;
  logic                    acc_fits;
  logic [NUM_W-1:0]        mag;
  logic [REM_W:0]          trial;
  logic                    qbit;
  logic signed [VALUE_W-1:0] q48;

  always_comb begin
    s = samp_q[RAW_W-1:0];
    case (cmd_i.coef_sel)
      2'd0:    coef_next = coef_b_q;
      2'd1:    coef_next = coef_c_q;
      default: coef_next = coef_d_q;
    endcase
    horner_sum = prod_q + ACC_W'(coef_next);
    acc_fits   = (mcand_q[ACC_W-1:VALUE_W-1] == '0) ||
                 (mcand_q[ACC_W-1:VALUE_W-1] == '1);
    mag   = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
    trial = {rem_q, dvd_q[DIV_W-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    q48   = VALUE_W'(dvd_q);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        samp_q  <= in_sample_i;
        xs_q    <= in_sample_i;
        mcand_q <= ACC_W'(coef_a_q);
        prod_q  <= '0;
        if (in_kind_i) begin
          res_value_q  <= '0;
          res_status_q <= STAT_WRITTEN;
        end else begin
          res_value_q  <= VALUE_W'(in_sample_i) <<< FRAC_W;
          res_status_q <= STAT_OK;
        end
      end
      OP_MUL_BIT: begin
        if (xs_q[0]) begin
          prod_q <= cmd_i.msb ? prod_q - mcand_q : prod_q + mcand_q;
        end
        mcand_q <= mcand_q <<< 1;
        xs_q    <= xs_q >> 1;
      end
      OP_ADD_COEF: begin
        mcand_q <= horner_sum;
        prod_q  <= '0;
        xs_q    <= samp_q;
      end
      OP_RES_POLY: begin
        if (acc_fits) begin
          res_value_q  <= VALUE_W'(mcand_q);
          res_status_q <= STAT_OK;
        end else begin
          res_value_q  <= mcand_q[ACC_W-1] ? VAL_MIN : VAL_MAX;
          res_status_q <= STAT_SAT;
        end
      end
      OP_RES_RDATA: begin
        res_value_q  <= VALUE_W'(rd_phys);
        res_status_q <= STAT_OK;
      end
      OP_RES_LO: begin
        res_value_q  <= VALUE_W'(lo_phys_q);
        res_status_q <= STAT_OK;
      end
      OP_RES_NONE: begin
        res_value_q  <= '0;
        res_status_q <= STAT_NO_INTERVAL;
      end
      OP_KEEP_LO: begin
        lo_raw_q  <= rd_raw;
        lo_phys_q <= rd_phys;
      end
      OP_INTERP_SETUP: begin
        dphys_q <= DPHY_W'(rd_phys) - DPHY_W'(lo_phys_q);
        ds_q    <= s - lo_raw_q;
        dw_q    <= rd_raw - lo_raw_q;
      end
      OP_MUL_TBL: begin
        num_q <= NUM_W'(dphys_q * $signed({1'b0, ds_q}));
      end
      OP_DIV_PREP: begin
        neg_q <= num_q[NUM_W-1];
        dvd_q <= {mag, 1'b0} + DIV_W'(dw_q);
        dvs_q <= {dw_q, 1'b0};
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= qbit ? REM_W'(trial - {1'b0, dvs_q}) : REM_W'(trial);
        dvd_q <= {dvd_q[DIV_W-2:0], qbit};
      end
      OP_RES_INTERP: begin
        res_value_q  <= VALUE_W'(lo_phys_q) + (neg_q ? -q48 : q48);
        res_status_q <= STAT_OK;
      end
      default: ;
    endcase
  end

  logic out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [STATUS_W-1:0] out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.in_kind    = in_kind_i;
    sts_o.le_rd      = (s <= rd_raw);
    sts_o.ge_rd      = (s >= rd_raw);
    sts_o.in_lo      = (lo_raw_q <= s) && (s <= rd_raw);
    sts_o.zero_width = (rd_raw == lo_raw_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STAT_SAT) |->
      (out_value_q == VAL_MAX || out_value_q == VAL_MIN))
    else $error("saturated word is not at a range bound");

endmodule
`default_nettype wire

### design/sensor_raw_to_physical_converter.sv
// Top level of the raw-sample to physical-value converter.
// A table write or pass-through goes from acceptance to S_DONE, then to the registered output word once it is free.
// Polynomial modes run one Horner step per degree, each a 17-step serial multiplier and a coefficient add.
// Table mode does one memory read per point to find the interval, then a 51-step divider.
// One word is worked on at a time; the next is accepted while the result awaits collection.
// Reset is asynchronous and active low; it clears control and configuration, not the table.
`default_nettype none
module sensor_raw_to_physical_converter import srpc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  srpc_in_if.sink                    in_if,
  srpc_out_if.source                 out_if,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] last_idx;

  srpc_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .last_idx_i (last_idx),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  srpc_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_kind_i        (in_if.kind),
    .in_sample_i      (in_if.sample),
    .in_point_index_i (in_if.point_index),
    .in_point_raw_i   (in_if.point_raw),
    .in_point_phys_i  (in_if.point_phys),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .sts_o            (sts),
    .last_idx_o       (last_idx),
    .out_valid_o      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .out_value_o      (out_if.value),
    .out_status_o     (out_if.status)
  );
endmodule
`default_nettype wire
